>>> rtl/core/prc_pkg.sv
// ----------------------------------------------------------------------------
// Prefix route classifier package
// Shared widths, codes, table entry layout and the prefix mask function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prc_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int NUM_LINKS   = 16;
   localparam int ADDR_W      = 32;
   localparam int PLEN_W      = 6;
   localparam int LINK_W      = 4;
   localparam int COUNT_W     = 32;
   localparam int CFG_W       = 7;
   localparam int INDEX_W     = 6;
   localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
   localparam int LINK_IDX_W  = $clog2(NUM_LINKS);
   localparam int CSR_IDX_W   = 1;

   typedef enum logic [0:0] {
      OP_WRITE_ENTRY = 1'b0,
      OP_CLASSIFY    = 1'b1
   } opcode_type;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_FILTER_COUNT = 1'b0;
   localparam csr_index_type REG_ROUTE_COUNT  = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [PLEN_W-1:0] prefix_len;
      logic [LINK_W-1:0] link;
   } table_entry_type;

   // Prefix length already limited to ADDR_W; a length of zero gives an empty mask.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] eff_len);
      prefix_mask = ~({ADDR_W{1'b1}} >> eff_len);
   endfunction

endpackage

>>> rtl/core/prc_if.sv
// ----------------------------------------------------------------------------
// Prefix route classifier channels
// Valid/ready channel interfaces for requests, responses and CSR writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface prc_req_if;
   logic                              valid;
   logic                              ready;
   prc_pkg::opcode_type               opcode;
   logic [prc_pkg::INDEX_W-1:0]       entry_index;
   logic [prc_pkg::ADDR_W-1:0]        entry_address;
   logic [prc_pkg::PLEN_W-1:0]        entry_prefix_len;
   logic [prc_pkg::LINK_W-1:0]        entry_link;
   logic [prc_pkg::ADDR_W-1:0]        packet_address;

   modport source (output valid, opcode, entry_index, entry_address, entry_prefix_len,
                   entry_link, packet_address, input ready);
   modport sink   (input valid, opcode, entry_index, entry_address, entry_prefix_len,
                   entry_link, packet_address, output ready);
endinterface

interface prc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [prc_pkg::LINK_W-1:0]        link;
   logic                              matched;
   logic [prc_pkg::COUNT_W-1:0]       link_count;

   modport source (output valid, link, matched, link_count, input ready);
   modport sink   (input valid, link, matched, link_count, output ready);
endinterface

interface prc_csr_if;
   logic                              valid;
   logic                              ready;
   prc_pkg::csr_index_type            index;
   logic [prc_pkg::CFG_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/prefix_route_classifier.sv
// ----------------------------------------------------------------------------
// Prefix route classifier
// IPv4 longest-prefix-match classifier with leading filter entries and
// saturating per-link packet counters.
//
//   Channel    Role    Transaction
//   req_chan   sink    write a table entry, or classify one packet address
//   rsp_chan   source  chosen link, matched flag, new link count
//   csr_chan   sink    write filter_count (index 0) or route_count (index 1)
//
// A write-entry transaction updates the table as it is accepted. A classify
// transaction reads the clamped filter entries, then the clamped route entries
// (at most 64 in total): the single table memory read port delivers one entry
// per cycle, then the link counter is read and written back.
// Reset is synchronous; it clears the configuration and marks every link
// counter as zero. Table entries are undefined until written.
// A finished result waits in the output register while the next transaction
// is accepted; a classify only stalls in its last step while that register
// is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_route_classifier (
   input  logic       clock,
   input  logic       reset,
   prc_req_if.sink    req_chan,
   prc_rsp_if.source  rsp_chan,
   prc_csr_if.sink    csr_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CNT_RD,
      S_CNT_WR
   } state_type;

   localparam int CW = prc_pkg::CFG_W;

   // Control and configuration state.
   state_type                          state_ff, state_in;
   logic [CW-1:0]                      filter_count_ff, filter_count_in;
   logic [CW-1:0]                      route_count_ff, route_count_in;
   logic [CW-1:0]                      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                      total_ff, total_in;
   logic [CW-1:0]                      nf_ff, nf_in;
   logic                               chk_valid_ff, chk_valid_in;
   logic [CW-1:0]                      chk_idx_ff, chk_idx_in;
   logic                               hit_ff, hit_in;
   logic                               filter_hit_ff, filter_hit_in;
   logic [prc_pkg::PLEN_W-1:0]         best_len_ff, best_len_in;
   logic [prc_pkg::LINK_W-1:0]         best_link_ff, best_link_in;
   logic [prc_pkg::LINK_W-1:0]         sel_link_ff, sel_link_in;
   logic [prc_pkg::ADDR_W-1:0]         pkt_addr_ff, pkt_addr_in;
   logic [prc_pkg::NUM_LINKS-1:0]      cnt_vld_ff, cnt_vld_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [prc_pkg::LINK_W-1:0]         rsp_link_ff, rsp_link_in;
   logic                               rsp_matched_ff, rsp_matched_in;
   logic [prc_pkg::COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   // Memories and their read data registers.
   prc_pkg::table_entry_type           tbl_mem_ff [prc_pkg::TABLE_DEPTH];
   prc_pkg::table_entry_type           tbl_rdata_ff;
   logic [prc_pkg::COUNT_W-1:0]        cnt_mem_ff [prc_pkg::NUM_LINKS];
   logic [prc_pkg::COUNT_W-1:0]        cnt_rdata_ff;
   logic                               cnt_rvld_ff;

   logic                               tbl_we, tbl_re, cnt_re, cnt_we;
   logic                               req_fire;
   logic [CW-1:0]                      nf_clamp, room, nr_clamp;
   logic [prc_pkg::PLEN_W-1:0]         entry_len;
   logic                               entry_match;
   logic [prc_pkg::LINK_W-1:0]         sel_link;
   logic [prc_pkg::COUNT_W-1:0]        cnt_old, cnt_new;
   prc_pkg::table_entry_type           wr_entry;

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.link      = rsp_link_ff;
   assign rsp_chan.matched   = rsp_matched_ff;
   assign rsp_chan.link_count = rsp_count_ff;

   assign req_fire = req_chan.valid && req_chan.ready;

   // Filters are clamped to the table, routes to the room left after them.
   assign nf_clamp = (filter_count_ff > CW'(prc_pkg::TABLE_DEPTH)) ?
                     CW'(prc_pkg::TABLE_DEPTH) : filter_count_ff;
   assign room     = CW'(prc_pkg::TABLE_DEPTH) - nf_clamp;
   assign nr_clamp = (route_count_ff > room) ? room : route_count_ff;

   assign wr_entry.address    = req_chan.entry_address;
   assign wr_entry.prefix_len = req_chan.entry_prefix_len;
   assign wr_entry.link       = req_chan.entry_link;

   // Compare stage: the entry read in the previous cycle against the packet.
   assign entry_len   = (tbl_rdata_ff.prefix_len > prc_pkg::PLEN_W'(prc_pkg::ADDR_W)) ?
                        prc_pkg::PLEN_W'(prc_pkg::ADDR_W) : tbl_rdata_ff.prefix_len;
   assign entry_match = ((pkt_addr_ff ^ tbl_rdata_ff.address) &
                         prc_pkg::prefix_mask(entry_len)) == '0;

   // A link number outside the counter bank is folded onto the discard link.
   assign sel_link = (hit_ff && (32'(best_link_ff) < prc_pkg::NUM_LINKS)) ?
                     best_link_ff : '0;

   // A counter that was never written since reset reads as zero.
   assign cnt_old = cnt_rvld_ff ? cnt_rdata_ff : '0;
   assign cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + prc_pkg::COUNT_W'(1);

   always_comb begin
      state_in        = state_ff;
      filter_count_in = filter_count_ff;
      route_count_in  = route_count_ff;
      rd_ptr_in       = rd_ptr_ff;
      total_in        = total_ff;
      nf_in           = nf_ff;
      chk_valid_in    = 1'b0;
      chk_idx_in      = chk_idx_ff;
      hit_in          = hit_ff;
      filter_hit_in   = filter_hit_ff;
      best_len_in     = best_len_ff;
      best_link_in    = best_link_ff;
      sel_link_in     = sel_link_ff;
      pkt_addr_in     = pkt_addr_ff;
      cnt_vld_in      = cnt_vld_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_link_in     = rsp_link_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_count_in    = rsp_count_ff;
      tbl_we          = 1'b0;
      tbl_re          = 1'b0;
      cnt_re          = 1'b0;
      cnt_we          = 1'b0;

      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            prc_pkg::REG_FILTER_COUNT: filter_count_in = csr_chan.data;
            prc_pkg::REG_ROUTE_COUNT:  route_count_in  = csr_chan.data;
         endcase
      end

      // Filters are scanned before routes, so the first filter that matches
      // locks the result; a route only wins with a strictly longer prefix,
      // which keeps ties on the lowest index.
      if (chk_valid_ff && entry_match && !filter_hit_ff) begin
         if (chk_idx_ff < nf_ff) begin
            filter_hit_in = 1'b1;
            hit_in        = 1'b1;
            best_link_in  = tbl_rdata_ff.link;
         end else if (!hit_ff || (entry_len > best_len_ff)) begin
            hit_in        = 1'b1;
            best_len_in   = entry_len;
            best_link_in  = tbl_rdata_ff.link;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.opcode == prc_pkg::OP_WRITE_ENTRY) begin
                  tbl_we = 1'b1;
               end else begin
                  pkt_addr_in   = req_chan.packet_address;
                  nf_in         = nf_clamp;
                  total_in      = nf_clamp + nr_clamp;
                  rd_ptr_in     = '0;
                  hit_in        = 1'b0;
                  filter_hit_in = 1'b0;
                  best_len_in   = '0;
                  best_link_in  = '0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_ptr_ff != total_ff) begin
               tbl_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_ptr_ff;
               rd_ptr_in    = rd_ptr_ff + CW'(1);
            end else begin
               // The last entry is compared in this cycle.
               state_in = S_CNT_RD;
            end
         end
         S_CNT_RD: begin
            cnt_re      = 1'b1;
            sel_link_in = sel_link;
            state_in    = S_CNT_WR;
         end
         S_CNT_WR: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               cnt_we = 1'b1;
               cnt_vld_in[sel_link_ff[prc_pkg::LINK_IDX_W-1:0]] = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_link_in    = sel_link_ff;
               rsp_matched_in = hit_ff;
               rsp_count_in   = cnt_new;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         filter_count_ff <= '0;
         route_count_ff  <= '0;
         chk_valid_ff    <= 1'b0;
         cnt_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         rd_ptr_ff       <= '0;
         total_ff        <= '0;
         hit_ff          <= 1'b0;
         filter_hit_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         filter_count_ff <= filter_count_in;
         route_count_ff  <= route_count_in;
         chk_valid_ff    <= chk_valid_in;
         cnt_vld_ff      <= cnt_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         rd_ptr_ff       <= rd_ptr_in;
         total_ff        <= total_in;
         hit_ff          <= hit_in;
         filter_hit_ff   <= filter_hit_in;
      end
      nf_ff          <= nf_in;
      chk_idx_ff     <= chk_idx_in;
      best_len_ff    <= best_len_in;
      best_link_ff   <= best_link_in;
      sel_link_ff    <= sel_link_in;
      pkt_addr_ff    <= pkt_addr_in;
      rsp_link_ff    <= rsp_link_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // Route table: one write port for entry updates, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem_ff[req_chan.entry_index[prc_pkg::TBL_IDX_W-1:0]] <= wr_entry;
      end
      if (tbl_re) begin
         tbl_rdata_ff <= tbl_mem_ff[rd_ptr_ff[prc_pkg::TBL_IDX_W-1:0]];
      end
   end

   // Link counters: read in the counter read step, written back in the counter write step.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[sel_link_ff[prc_pkg::LINK_IDX_W-1:0]] <= cnt_new;
      end
      if (cnt_re) begin
         cnt_rdata_ff <= cnt_mem_ff[sel_link[prc_pkg::LINK_IDX_W-1:0]];
         cnt_rvld_ff  <= cnt_vld_ff[sel_link[prc_pkg::LINK_IDX_W-1:0]];
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_count_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_CNT_WR))
      else $error("response loaded outside the counter write step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rd_ptr_ff <= total_ff) &&
                               (total_ff <= CW'(prc_pkg::TABLE_DEPTH)))
      else $error("scan pointer beyond the active table");

   a_unmatched_discard: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_matched_ff) |-> (rsp_link_ff == '0))
      else $error("unmatched packet not sent to the discard link");

   a_no_compare_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !chk_valid_ff)
      else $error("table compare pending while idle");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (rsp_count_ff != '0))
      else $error("incremented link count reads zero");
`endif

endmodule

>>> verif/prc_tb_pkg.sv
// ----------------------------------------------------------------------------
// Prefix route classifier verification package
// Transaction types and the scoreboard that predicts and checks every route.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prc_tb_pkg;

   import prc_pkg::*;

   typedef struct {
      opcode_type           opcode;
      logic [INDEX_W-1:0]   index;
      logic [ADDR_W-1:0]    entry_address;
      logic [PLEN_W-1:0]    prefix_len;
      logic [LINK_W-1:0]    link;
      logic [ADDR_W-1:0]    packet_address;
   } route_cmd_type;

   typedef struct {
      logic [LINK_W-1:0]    link;
      logic                 matched;
      logic [COUNT_W-1:0]   link_count;
   } route_result_type;

   class route_scoreboard;
      logic [ADDR_W-1:0]    entry_addr [TABLE_DEPTH];
      logic [PLEN_W-1:0]    entry_plen [TABLE_DEPTH];
      logic [LINK_W-1:0]    entry_link [TABLE_DEPTH];
      logic [COUNT_W-1:0]   link_hits [NUM_LINKS];
      logic [CFG_W-1:0]     filter_count;
      logic [CFG_W-1:0]     route_count;
      route_result_type     expected_routes [$];
      int                   error_count;

      function new();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_addr[i] = '0;
            entry_plen[i] = '0;
            entry_link[i] = '0;
         end
         for (int i = 0; i < NUM_LINKS; i++) begin
            link_hits[i] = '0;
         end
         filter_count = '0;
         route_count  = '0;
         error_count  = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_FILTER_COUNT: begin
               filter_count = value;
            end
            REG_ROUTE_COUNT: begin
               route_count = value;
            end
            default: begin
            end
         endcase
      endfunction

      // Lengths above the address width behave as a full-width prefix.
      function int unsigned clamp_len(int idx);
         return (entry_plen[idx] > ADDR_W) ? ADDR_W : int'(entry_plen[idx]);
      endfunction

      function bit entry_hit(int idx, logic [ADDR_W-1:0] dest);
         int unsigned      len;
         logic [ADDR_W-1:0] mask;
         len  = clamp_len(idx);
         mask = (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
         return ((dest ^ entry_addr[idx]) & mask) == '0;
      endfunction

      function route_result_type predict_route(logic [ADDR_W-1:0] dest);
         route_result_type res;
         int            nf;
         int            nr;
         int            best;
         bit            hit;
         int            lk;
         nf   = (filter_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(filter_count);
         nr   = (route_count > TABLE_DEPTH - nf) ? TABLE_DEPTH - nf : int'(route_count);
         hit  = 1'b0;
         best = 0;
         for (int i = 0; i < nf; i++) begin
            if (entry_hit(i, dest)) begin
               hit  = 1'b1;
               best = i;
               break;
            end
         end
         if (!hit) begin
            // Strictly longer wins, so an equal length keeps the lower index.
            for (int i = nf; i < nf + nr; i++) begin
               if (entry_hit(i, dest) && (!hit || clamp_len(i) > clamp_len(best))) begin
                  hit  = 1'b1;
                  best = i;
               end
            end
         end
         lk = hit ? int'(entry_link[best]) : 0;
         if (lk >= NUM_LINKS) begin
            lk = 0;
         end
         if (link_hits[lk] != {COUNT_W{1'b1}}) begin
            link_hits[lk] = link_hits[lk] + COUNT_W'(1);
         end
         res.link       = lk[LINK_W-1:0];
         res.matched    = hit;
         res.link_count = link_hits[lk];
         return res;
      endfunction

      function void note_request(route_cmd_type cmd);
         if (cmd.opcode == OP_WRITE_ENTRY) begin
            if (int'(cmd.index) < TABLE_DEPTH) begin
               entry_addr[cmd.index] = cmd.entry_address;
               entry_plen[cmd.index] = cmd.prefix_len;
               entry_link[cmd.index] = cmd.link;
            end
         end else begin
            expected_routes.push_back(predict_route(cmd.packet_address));
         end
      endfunction

      function void check_response(logic [LINK_W-1:0] link, logic matched,
                                   logic [COUNT_W-1:0] link_count);
         route_result_type want;
         if (expected_routes.size() == 0) begin
            $display("%0t: unexpected result link=%0d matched=%0d count=%0d",
                     $time, link, matched, link_count);
            error_count++;
            return;
         end
         want = expected_routes.pop_front();
         if (link !== want.link) begin
            $display("%0t: link mismatch expected=%0d actual=%0d",
                     $time, want.link, link);
            error_count++;
         end
         if (matched !== want.matched) begin
            $display("%0t: matched mismatch expected=%0d actual=%0d",
                     $time, want.matched, matched);
            error_count++;
         end
         if (link_count !== want.link_count) begin
            $display("%0t: link_count mismatch expected=%0d actual=%0d",
                     $time, want.link_count, link_count);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_routes.size();
      endfunction
   endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Prefix route classifier testbench
// Loads the route table, sweeps the filter and route counts through a set of
// settings, and classifies directed and random destinations under random
// backpressure. A scoreboard predicts each route and checks every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   import prc_pkg::*;
   import prc_tb_pkg::*;

   // The quiet wait covers a busy block after the last response has already been
   // returned.
   localparam int QUIET_CYCLES   = 100;
   localparam int NUM_PHASES     = 10;
   localparam int PHASE_ITEMS    = 52;
   localparam int DIRECTED_CFGS  = 8;

   logic clock;
   logic reset;

   prc_req_if req_bus ();
   prc_rsp_if rsp_bus ();
   prc_csr_if csr_bus ();

   route_scoreboard sb = new();

   // Turns random gaps and response stalls on or off for the current phase.
   bit idling_on;
   int stall_left = 0;

   prefix_route_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_chan  (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net: the slowest correct run is far below this bound.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Response side. Handshakes are sampled right after the edge, so the
   // values seen are the ones that were present at the edge. The ready line
   // drops in random bursts while idling is on, and a burst ends at once
   // when idling is turned off.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_response(rsp_bus.link, rsp_bus.matched, rsp_bus.link_count);
      end
      if (idling_on && stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(1, 18) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left    <= 0;
      end
   end

   // Presents one transaction, optionally after an idle burst, and hands it
   // to the scoreboard once it has been accepted. Valid is left high so that
   // back-to-back transactions need only one assignment per edge.
   task automatic send_cmd(input route_cmd_type cmd);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.opcode           <= cmd.opcode;
      req_bus.entry_index      <= cmd.index;
      req_bus.entry_address    <= cmd.entry_address;
      req_bus.entry_prefix_len <= cmd.prefix_len;
      req_bus.entry_link       <= cmd.link;
      req_bus.packet_address   <= cmd.packet_address;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(cmd);
   endtask

   // Unused fields of each transaction carry random values so that every
   // bit of the channel toggles.
   task automatic write_entry(input int idx, input logic [ADDR_W-1:0] addr,
                              input logic [PLEN_W-1:0] plen,
                              input logic [LINK_W-1:0] link);
      route_cmd_type cmd;
      cmd.opcode         = OP_WRITE_ENTRY;
      cmd.index          = idx[INDEX_W-1:0];
      cmd.entry_address  = addr;
      cmd.prefix_len     = plen;
      cmd.link           = link;
      cmd.packet_address = $urandom;
      send_cmd(cmd);
   endtask

   task automatic classify(input logic [ADDR_W-1:0] dest);
      route_cmd_type cmd;
      cmd.opcode         = OP_CLASSIFY;
      cmd.index          = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      cmd.entry_address  = $urandom;
      cmd.prefix_len     = PLEN_W'($urandom_range(0, 63));
      cmd.link           = LINK_W'($urandom_range(0, 15));
      cmd.packet_address = dest;
      send_cmd(cmd);
   endtask

   // Mostly ordinary lengths, with some zero and some beyond 32 bits.
   function automatic logic [PLEN_W-1:0] random_plen();
      case ($urandom_range(0, 9))
         0:       return PLEN_W'($urandom_range(33, 63));
         1:       return '0;
         default: return PLEN_W'($urandom_range(1, 32));
      endcase
   endfunction

   // Random entries often reuse an address already in the table, so that
   // equal and nested prefixes compete for the same destinations.
   task automatic write_random_entry(input int idx);
      logic [ADDR_W-1:0] addr;
      if ($urandom_range(0, 2) == 0) begin
         addr = sb.entry_addr[$urandom_range(0, TABLE_DEPTH - 1)];
      end else begin
         addr = $urandom;
      end
      write_entry(idx, addr, random_plen(), LINK_W'($urandom_range(0, 15)));
   endtask

   // Most destinations sit near a table entry: only the bits below a random cut
   // are flipped, so the entry and anything shorter on that path still match when their prefix ends above the cut.
   function automatic logic [ADDR_W-1:0] random_packet();
      int j;
      j = $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 9))
         6, 7:    return $urandom;
         8:       return ($urandom_range(0, 1) == 1) ? {ADDR_W{1'b1}} : '0;
         default: return sb.entry_addr[j] ^ ($urandom >> $urandom_range(0, 32));
      endcase
   endfunction

   // Waits until every expected result has arrived, then gives the block
   // time to finish any table write still in flight.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Writes both counts; valid stays high across the pair of transactions.
   task automatic write_config(input logic [CFG_W-1:0] filters,
                               input logic [CFG_W-1:0] routes);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= REG_FILTER_COUNT;
      csr_bus.data  <= filters;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_register(REG_FILTER_COUNT, filters);
      csr_bus.index <= REG_ROUTE_COUNT;
      csr_bus.data  <= routes;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_register(REG_ROUTE_COUNT, routes);
      csr_bus.valid <= 1'b0;
   endtask

   // Directed count settings: all routes, all filters, a mix, values beyond
   // the table that must be clamped, an empty table, and uneven splits.
   logic [CFG_W-1:0] cfg_filters [DIRECTED_CFGS] = '{7'd0, 7'd64, 7'd8, 7'd127,
                                                     7'd0, 7'd32, 7'd1, 7'd3};
   logic [CFG_W-1:0] cfg_routes  [DIRECTED_CFGS] = '{7'd64, 7'd0, 7'd24, 7'd127,
                                                     7'd0, 7'd32, 7'd63, 7'd100};

   initial begin
      req_bus.valid            <= 1'b0;
      req_bus.opcode           <= OP_WRITE_ENTRY;
      req_bus.entry_index      <= '0;
      req_bus.entry_address    <= '0;
      req_bus.entry_prefix_len <= '0;
      req_bus.entry_link       <= '0;
      req_bus.packet_address   <= '0;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= REG_FILTER_COUNT;
      csr_bus.data             <= '0;
      idling_on  = 1'b1;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // With both counts at their reset value of zero no entry is read, so
      // packets may be classified before the table holds anything. They all
      // fall to the discard link without a match.
      classify('0);
      classify({ADDR_W{1'b1}});

      // Fill every slot so that no classify ever reads an unwritten entry.
      // A few slots hold the interesting cases: a full-length host route,
      // a default route that matches everything, lengths beyond 32 bits,
      // a matching entry that points at the discard link, and two equal
      // prefixes where the lower slot has to win the tie.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (i)
            0:       write_entry(i, 32'hFFFF_FFFF, 6'd32, 4'd15);
            2:       write_entry(i, 32'hC0A8_0000, 6'd40, 4'd2);
            3:       write_entry(i, 32'h0A00_0000, 6'd63, 4'd0);
            4:       write_entry(i, 32'hAC10_0000, 6'd16, 4'd4);
            5:       write_entry(i, 32'hAC10_0000, 6'd16, 4'd5);
            40:      write_entry(i, 32'h1234_5678, 6'd0, 4'd1);
            default: write_random_entry(i);
         endcase
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         quiesce();
         if (phase < DIRECTED_CFGS) begin
            write_config(cfg_filters[phase], cfg_routes[phase]);
         end else begin
            write_config(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 70)));
         end
         // The final phase runs at full speed on both sides; elsewhere some
         // phases are also left free of idling.
         idling_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);

         // Extremes and the directed slots under the first three count settings.
         if (phase < 3) begin
            classify('0);
            classify({ADDR_W{1'b1}});
            classify(32'hC0A8_0000);
            classify(32'hC0A8_0001);
            classify(32'h0A00_0000);
            classify(32'hAC10_BEEF);
         end

         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               write_random_entry($urandom_range(0, TABLE_DEPTH - 1));
            end else begin
               classify(random_packet());
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);

      if (sb.error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> prefix_route_classifier.f
rtl/core/prc_pkg.sv
rtl/core/prc_if.sv
rtl/core/prefix_route_classifier.sv
verif/prc_tb_pkg.sv
verif/tb_top.sv
